// ===== hw/rtl/rle16_pkg.sv =====
package rle16_pkg;

    localparam int POS_BITS       = 21;
    localparam int BYTE_BITS      = 8;
    localparam int WORD_BITS      = 16;
    localparam int LEN_BITS       = 8;
    localparam int CODE_BITS      = 7;
    localparam int PIX_FIELD_BITS = 20;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 21;

    localparam logic [CFG_INDEX_BITS-1:0] REG_DELTA_MODE   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_PIXELS = 2'd1;

    localparam logic [POS_BITS-1:0] FRAME_PIXELS_RESET = 21'd307200;
    localparam logic [POS_BITS-1:0] POS_MAX            = 21'h1FFFFF;

    typedef enum logic [2:0] {
        PH_CTRL   = 3'd0,
        PH_LIT_LO = 3'd1,
        PH_LIT_HI = 3'd2,
        PH_REP_LO = 3'd3,
        PH_REP_HI = 3'd4
    } phase_t;

    typedef struct packed {
        logic [POS_BITS-1:0]  pos;
        logic [LEN_BITS-1:0]  run_len;
        logic [WORD_BITS-1:0] value;
        logic                 overrun;
        logic                 frame_end;
    } run_t;

endpackage

// ===== hw/rtl/rle16_parser.sv =====
module rle16_parser (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  logic [rle16_pkg::BYTE_BITS-1:0] data_byte,
    input  logic                          last_byte,
    input  logic                          delta_mode,
    input  logic [rle16_pkg::POS_BITS-1:0] frame_pixels,
    output logic                          res_valid,
    output rle16_pkg::run_t               res
);
    import rle16_pkg::*;

    phase_t                phase_reg,  phase_next;
    logic [LEN_BITS-1:0]   words_reg,  words_next;
    logic [CODE_BITS-1:0]  rep_reg,    rep_next;
    logic [BYTE_BITS-1:0]  low_reg,    low_next;
    logic [POS_BITS-1:0]   pos_reg,    pos_next;

    logic                  emit;
    logic [LEN_BITS-1:0]   len;
    logic [WORD_BITS-1:0]  value;
    logic [LEN_BITS-1:0]   adv_amt;
    logic [LEN_BITS-1:0]   words_dec;
    logic [POS_BITS:0]     adv_sum;
    logic [POS_BITS-1:0]   pos_adv;
    logic [POS_BITS-1:0]   res_pos;
    logic [POS_BITS:0]     end_sum;

    assign words_dec = words_reg - 8'd1;

    always_comb
    begin
        phase_next = phase_reg;
        words_next = words_reg;
        rep_next   = rep_reg;
        low_next   = low_reg;
        unique case (phase_reg)
            PH_CTRL:
            begin
                if (data_byte[BYTE_BITS-1])
                begin
                    words_next = LEN_BITS'(9'd256 - {1'b0, data_byte});
                    phase_next = PH_LIT_LO;
                end
                else if (!delta_mode)
                begin
                    rep_next   = data_byte[CODE_BITS-1:0];
                    phase_next = PH_REP_LO;
                end
            end
            PH_LIT_LO:
            begin
                low_next   = data_byte;
                phase_next = PH_LIT_HI;
            end
            PH_LIT_HI:
            begin
                words_next = words_dec;
                phase_next = (words_dec == '0) ? PH_CTRL : PH_LIT_LO;
            end
            PH_REP_LO:
            begin
                low_next   = data_byte;
                phase_next = PH_REP_HI;
            end
            default:
            begin
                phase_next = PH_CTRL;
            end
        endcase
    end

    always_comb
    begin
        emit    = 1'b0;
        len     = '0;
        value   = '0;
        adv_amt = '0;
        unique case (phase_reg)
            PH_CTRL:
            begin
                if (!data_byte[BYTE_BITS-1] && delta_mode)
                begin
                    adv_amt = data_byte + 8'd1;
                end
            end
            PH_LIT_HI:
            begin
                emit    = 1'b1;
                len     = 8'd1;
                value   = {data_byte, low_reg};
                adv_amt = 8'd1;
            end
            PH_REP_HI:
            begin
                emit    = 1'b1;
                len     = {1'b0, rep_reg} + 8'd2;
                value   = {data_byte, low_reg};
                adv_amt = len;
            end
            default:
            begin
            end
        endcase
    end

    assign adv_sum = {1'b0, pos_reg} + (POS_BITS+1)'(adv_amt);
    assign pos_adv = adv_sum[POS_BITS] ? POS_MAX : adv_sum[POS_BITS-1:0];
    assign res_pos = emit ? pos_reg : pos_adv;
    assign end_sum = {1'b0, res_pos} + (POS_BITS+1)'(len);

    always_comb
    begin
        res_valid     = emit | last_byte;
        res.pos       = res_pos;
        res.run_len   = len;
        res.value     = value;
        res.overrun   = end_sum > {1'b0, frame_pixels};
        res.frame_end = last_byte;
        pos_next      = last_byte ? '0 : pos_adv;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_CTRL;
            words_reg <= '0;
            rep_reg   <= '0;
            low_reg   <= '0;
            pos_reg   <= '0;
        end
        else if (fire)
        begin
            if (last_byte)
            begin
                phase_reg <= PH_CTRL;
                words_reg <= '0;
                rep_reg   <= '0;
                low_reg   <= '0;
            end
            else
            begin
                phase_reg <= phase_next;
                words_reg <= words_next;
                rep_reg   <= rep_next;
                low_reg   <= low_next;
            end
            pos_reg <= pos_next;
        end
    end

endmodule

// ===== hw/rtl/rle16_frame_decoder.sv =====
// Run-length decoder for one frame of 16-bit pixels. Payload bytes enter one
// per request on the input channel; each literal word or repeat group leaves
// as one run request (start index, length, value), and the last byte of the
// frame always yields a request with frame_end set. One byte is taken every
// cycle when the output side is not stalled; a byte passes an input register
// and the parser into the result register. in_stall follows out_stall in the
// same cycle only while both registers hold a request. Configuration writes
// are always ready.
module rle16_frame_decoder #(
    parameter int PIXEL_INDEX_BITS = 20
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [rle16_pkg::BYTE_BITS-1:0]        data_byte,
    input  logic                                   last_byte,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [PIXEL_INDEX_BITS-1:0]            pixel_index,
    output logic [rle16_pkg::LEN_BITS-1:0]         run_length,
    output logic [rle16_pkg::WORD_BITS-1:0]        pixel_value,
    output logic                                   overrun,
    output logic                                   frame_end,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [rle16_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [rle16_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import rle16_pkg::*;

    localparam int IDX_KEEP = (PIXEL_INDEX_BITS < PIX_FIELD_BITS) ?
                              PIXEL_INDEX_BITS : PIX_FIELD_BITS;

    logic                  delta_mode_reg;
    logic [POS_BITS-1:0]   frame_pixels_reg;

    logic                  in_valid_reg, in_valid_next;
    logic [BYTE_BITS-1:0]  byte_reg;
    logic                  last_reg;

    logic                  out_valid_reg, out_valid_next;
    run_t                  out_run_reg;

    logic                  stage_fire;
    logic                  in_take;
    logic                  res_valid;
    run_t                  res;

    assign cfg_ready  = 1'b1;
    assign stage_fire = in_valid_reg & (~out_valid_reg | ~out_stall);
    assign in_stall   = in_valid_reg & ~stage_fire;
    assign in_take    = in_valid & ~in_stall;

    always_comb
    begin
        in_valid_next = in_take | (in_valid_reg & ~stage_fire);
        if (stage_fire)
        begin
            out_valid_next = res_valid;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delta_mode_reg   <= 1'b0;
            frame_pixels_reg <= FRAME_PIXELS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_DELTA_MODE:   delta_mode_reg   <= cfg_data[0];
                REG_FRAME_PIXELS: frame_pixels_reg <= cfg_data[POS_BITS-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            byte_reg <= data_byte;
            last_reg <= last_byte;
        end
        if (stage_fire)
        begin
            out_run_reg <= res;
        end
    end

    rle16_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (stage_fire),
        .data_byte    (byte_reg),
        .last_byte    (last_reg),
        .delta_mode   (delta_mode_reg),
        .frame_pixels (frame_pixels_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    assign out_valid   = out_valid_reg;
    assign pixel_index = PIXEL_INDEX_BITS'(out_run_reg.pos[IDX_KEEP-1:0]);
    assign run_length  = out_run_reg.run_len;
    assign pixel_value = out_run_reg.value;
    assign overrun     = out_run_reg.overrun;
    assign frame_end   = out_run_reg.frame_end;

endmodule
